@@ rtl/at_response_tag_detector_defines.svh @@
// -----------------------------------------------------------------------------
// at_response_tag_detector_defines
// assertion macros used by the response tag detector rtl
// -----------------------------------------------------------------------------
`ifndef AT_RESPONSE_TAG_DETECTOR_DEFINES_SVH
`define AT_RESPONSE_TAG_DETECTOR_DEFINES_SVH

// same-cycle implication, clocked on clk and disabled in reset
`define ATD_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk and disabled in reset
`define ATD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/atd_pkg.sv @@
// -----------------------------------------------------------------------------
// atd_pkg
// types, codes and the fixed response tag table of the response tag detector
// -----------------------------------------------------------------------------
package atd_pkg;

	localparam int TAG_SLOTS      = 8;
	localparam int TAG_MAX_LEN    = 11;
	localparam int CUSTOM_MAX_LEN = 16;

	typedef enum logic [1:0] {
		ACT_BYTE    = 2'd0,
		ACT_TICK    = 2'd1,
		ACT_RESTART = 2'd2,
		ACT_NONE    = 2'd3
	} atd_action_t;

	typedef enum logic [1:0] {
		ST_WAIT    = 2'd0,
		ST_MATCH   = 2'd1,
		ST_TIMEOUT = 2'd2,
		ST_UNUSED  = 2'd3
	} atd_status_t;

	localparam logic [1:0] MODE_TABLE    = 2'd0;
	localparam logic [1:0] MODE_SUFFIX   = 2'd1;
	localparam logic [1:0] MODE_ANYWHERE = 2'd2;

	localparam logic [2:0] REG_MATCH_MODE  = 3'd0;
	localparam logic [2:0] REG_TIMEOUT     = 3'd1;
	localparam logic [2:0] REG_TAG_LENGTH  = 3'd2;
	localparam logic [2:0] REG_TAG_LOW     = 3'd3;
	localparam logic [2:0] REG_TAG_HIGH    = 3'd4;

	localparam logic [2:0] TAG_IDX_FAIL   = 3'd2;
	localparam logic [2:0] TAG_IDX_CUSTOM = 3'd1;

	// table tags, last byte of the tag in bits 7:0
	localparam logic [TAG_MAX_LEN*8-1:0] TAG_TEXT [TAG_SLOTS] = '{
		88'h0D0A4F4B0D0A,
		88'h0D0A4552524F520D0A,
		88'h0D0A4641494C0D0A,
		88'h0D0A53454E44204F4B0D0A,
		88'h20434F4E4E4543540D0A,
		88'h0,
		88'h0,
		88'h0
	};

	localparam logic [3:0] TAG_LEN [TAG_SLOTS] = '{
		4'd6, 4'd9, 4'd8, 4'd11, 4'd10, 4'd0, 4'd0, 4'd0
	};

	typedef struct packed {
		logic [1:0]  match_mode;
		logic [15:0] timeout_ticks;
		logic [4:0]  tag_length;
		logic [63:0] tag_low;
		logic [63:0] tag_high;
	} atd_cfg_t;

endpackage

@@ rtl/atd_matcher.sv @@
// -----------------------------------------------------------------------------
// atd_matcher
// compares the newest window bytes against the tag table or the custom tag
// -----------------------------------------------------------------------------
module atd_matcher import atd_pkg::*; #(
	parameter int WINDOW_BYTES = 16,
	parameter int TABLE_TAGS   = 5,
	parameter int CNT_W        = 5
) (
	input  logic [WINDOW_BYTES-1:0][7:0] window,
	input  logic [CNT_W-1:0]             count,
	input  atd_cfg_t                     cfg,
	output logic                         hit,
	output logic [2:0]                   tag
);

	logic [TAG_SLOTS-1:0] table_ok;
	logic [31:0]          sfx_ok;
	logic [7:0]           tag_bytes [CUSTOM_MAX_LEN];
	logic                 cust_hit;
	logic                 enough;

	// table tags, compared from the newest byte backwards
	always_comb begin
		for (int t = 0; t < TAG_SLOTS; t++) begin
			table_ok[t] = (t < TABLE_TAGS) && (TAG_LEN[t] != '0) &&
				(int'(TAG_LEN[t]) <= WINDOW_BYTES) && (int'(count) >= int'(TAG_LEN[t]));
			for (int k = 0; k < TAG_MAX_LEN; k++) begin
				if (k < int'(TAG_LEN[t]) && k < WINDOW_BYTES) begin
					if (window[WINDOW_BYTES-1-k] != TAG_TEXT[t][8*k +: 8]) begin
						table_ok[t] = 1'b0;
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			tag_bytes[i]   = cfg.tag_low[8*i +: 8];
			tag_bytes[i+8] = cfg.tag_high[8*i +: 8];
		end
	end

	// one suffix compare per possible custom tag length
	always_comb begin
		sfx_ok = '0;
		for (int l = 1; l <= CUSTOM_MAX_LEN; l++) begin
			if (l <= WINDOW_BYTES) begin
				sfx_ok[l] = 1'b1;
				for (int i = 0; i < CUSTOM_MAX_LEN; i++) begin
					if (i < l) begin
						if (window[WINDOW_BYTES-l+i] != tag_bytes[i]) begin
							sfx_ok[l] = 1'b0;
						end
					end
				end
			end
		end
	end

	// anywhere mode needs one byte before the tag
	always_comb begin
		if (cfg.match_mode == MODE_ANYWHERE) begin
			enough = int'(count) >= int'(cfg.tag_length) + 1;
		end else begin
			enough = int'(count) >= int'(cfg.tag_length);
		end
		cust_hit = sfx_ok[cfg.tag_length] && enough;
	end

	always_comb begin
		hit = 1'b0;
		tag = '0;
		priority if (cfg.match_mode == MODE_TABLE) begin
			for (int t = TAG_SLOTS - 1; t >= 0; t--) begin
				if (table_ok[t]) begin
					hit = 1'b1;
					tag = 3'(t);
				end
			end
		end else if (cfg.match_mode == MODE_SUFFIX || cfg.match_mode == MODE_ANYWHERE) begin
			hit = cust_hit;
			tag = TAG_IDX_CUSTOM;
		end else begin
			hit = 1'b0;
		end
	end

endmodule

@@ rtl/at_response_tag_detector.sv @@
// -----------------------------------------------------------------------------
// at_response_tag_detector
// modem response ending detector with tick timeout and latched status
// -----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and gives one result
// beat per input beat: the beat is held in the input register, and from there
// the window shift, all tag compares and the status update feed the result
// register, which loads once the output is not stalled. Every tag is compared
// against the newest window bytes in that one step, so back-to-back beats flow at
// full rate as long as the output is not stalled. Configuration writes are
// taken at any time the write enable is high and should be made while idle.
// -----------------------------------------------------------------------------
`include "at_response_tag_detector_defines.svh"

module at_response_tag_detector import atd_pkg::*; #(
	parameter int WINDOW_BYTES = 16,
	parameter int TABLE_TAGS   = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  rx_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  tag_index,
	output logic        command_ok
);

	localparam int CNT_W = $clog2(WINDOW_BYTES + 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WINDOW_BYTES + 1);

	atd_cfg_t cfg_q;

	logic        valid_s1;
	atd_action_t action_s1;
	logic [7:0]  rx_byte_s1;
	logic        adv_s1;

	logic [WINDOW_BYTES-1:0][7:0] window_q, window_d;
	logic [CNT_W-1:0]             count_q, count_d;
	logic [15:0]                  tick_q, tick_d, tick_inc;
	atd_status_t                  status_q, status_d;
	logic [2:0]                   tag_q, tag_d;

	logic [WINDOW_BYTES-1:0][7:0] window_sh;
	logic [CNT_W-1:0]             count_sh;
	logic                         hit;
	logic [2:0]                   hit_tag;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_mode    <= MODE_TABLE;
			cfg_q.timeout_ticks <= 16'd1000;
			cfg_q.tag_length    <= 5'd2;
			cfg_q.tag_low       <= 64'h203E;
			cfg_q.tag_high      <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MATCH_MODE: cfg_q.match_mode    <= cfg_data[1:0];
				REG_TIMEOUT:    cfg_q.timeout_ticks <= cfg_data[15:0];
				REG_TAG_LENGTH: cfg_q.tag_length    <= cfg_data[4:0];
				REG_TAG_LOW:    cfg_q.tag_low       <= cfg_data;
				REG_TAG_HIGH:   cfg_q.tag_high      <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign adv_s1   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1  <= atd_action_t'(action);
			rx_byte_s1 <= rx_byte;
		end
	end

	// window after taking the byte
	always_comb begin
		for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
			window_sh[i] = window_q[i+1];
		end
		window_sh[WINDOW_BYTES-1] = rx_byte_s1;
		count_sh = (count_q < CNT_MAX) ? count_q + 1'b1 : count_q;
	end

	atd_matcher #(
		.WINDOW_BYTES (WINDOW_BYTES),
		.TABLE_TAGS   (TABLE_TAGS),
		.CNT_W        (CNT_W)
	) u_matcher (
		.window (window_sh),
		.count  (count_sh),
		.cfg    (cfg_q),
		.hit    (hit),
		.tag    (hit_tag)
	);

	assign tick_inc = (tick_q != '1) ? tick_q + 1'b1 : tick_q;

	always_comb begin
		window_d = window_q;
		count_d  = count_q;
		tick_d   = tick_q;
		status_d = status_q;
		tag_d    = tag_q;
		unique case (action_s1)
			ACT_BYTE: begin
				window_d = window_sh;
				count_d  = count_sh;
				if (status_q == ST_WAIT && hit) begin
					status_d = ST_MATCH;
					tag_d    = hit_tag;
				end
			end
			ACT_TICK: begin
				if (status_q == ST_WAIT) begin
					tick_d = tick_inc;
					if (tick_inc >= cfg_q.timeout_ticks) begin
						status_d = ST_TIMEOUT;
					end
				end
			end
			ACT_RESTART: begin
				window_d = '0;
				count_d  = '0;
				tick_d   = '0;
				tag_d    = '0;
				status_d = (cfg_q.timeout_ticks == '0) ? ST_TIMEOUT : ST_WAIT;
			end
			default: ;
		endcase
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			count_q  <= '0;
			tick_q   <= '0;
			status_q <= ST_WAIT;
			tag_q    <= '0;
		end else if (adv_s1) begin
			window_q <= window_d;
			count_q  <= count_d;
			tick_q   <= tick_d;
			status_q <= status_d;
			tag_q    <= tag_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status <= status_d;
			if (status_d == ST_MATCH) begin
				tag_index  <= tag_d;
				command_ok <= !(cfg_q.match_mode == MODE_TABLE && tag_d == TAG_IDX_FAIL);
			end else begin
				tag_index  <= '0;
				command_ok <= 1'b0;
			end
		end
	end

	`ATD_ASSERT(a_tag_only_on_match, out_valid && tag_index != '0, status == ST_MATCH, "tag index set without a match")
	`ATD_ASSERT(a_ok_only_on_match, out_valid && command_ok, status == ST_MATCH, "command ok set without a match")
	`ATD_ASSERT(a_count_bounded, 1'b1, count_q <= CNT_MAX, "byte count above window plus one")
	`ATD_ASSERT_NEXT(a_status_latched, adv_s1 && status_q != ST_WAIT && action_s1 != ACT_RESTART, $stable(status_q), "latched status changed without restart")

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Bench for the modem response tag detector. A short directed table covers
// reset state, the fixed-table FAIL ending, latching, timeout at restart and
// anywhere-mode history rules. Random phases then reprogram every register,
// mostly as restart / noise / tag-ending sequences (whole, cut or corrupted)
// with ticks mixed in. Every result beat is checked against the directed
// verdict or an in-bench model of the window, counters and latched status.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import atd_pkg::*;

	localparam int RANDOM_ITEMS = 1900;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 4;
	localparam int WIN          = 16;
	localparam int COUNT_CAP    = WIN + 1;
	localparam int TABLE_COUNT  = 5;
	localparam int CUSTOM_SLOT  = TABLE_COUNT;

	localparam logic [1:0] MODE_OFF  = 2'd3;
	localparam logic [2:0] REG_SPARE = 3'd7;

	// response endings, last byte in bits 7:0
	localparam logic [87:0] RESP_TAG [TABLE_COUNT] = '{
		{40'h0, 16'h0D0A, "OK", 16'h0D0A},
		{16'h0, 16'h0D0A, "ERROR", 16'h0D0A},
		{24'h0, 16'h0D0A, "FAIL", 16'h0D0A},
		{16'h0D0A, "SEND OK", 16'h0D0A},
		{8'h0, " CONNECT", 16'h0D0A}
	};
	localparam int RESP_LEN [TABLE_COUNT] = '{6, 9, 8, 11, 10};

	typedef struct {
		atd_status_t st;
		logic [2:0]  tag;
		logic        ok;
	} verdict_t;

	typedef struct {
		bit          wr;
		logic [2:0]  idx;
		logic [63:0] data;
		atd_action_t act;
		logic [7:0]  rx;
		bit          known;
		verdict_t    want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = '0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [2:0]  tag_index;
	logic        command_ok;

	at_response_tag_detector dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.tag_index  (tag_index),
		.command_ok (command_ok)
	);

	initial forever #1 clk = ~clk;

	// detector model: registers
	logic [1:0]  m_mode;
	logic [15:0] m_timeout;
	logic [4:0]  m_len;
	logic [63:0] m_low;
	logic [63:0] m_high;
	// detector model: history and latched status
	logic [7:0]  win_q [WIN];
	int          rx_count;
	logic [15:0] tick_cnt;
	atd_status_t cur_st;
	logic [2:0]  cur_tag;

	verdict_t verdict_q [$];
	verdict_t head;
	int       errors = 0;
	int       beats_sent = 0;
	int       cycle_count = 0;
	int       burst_left = 0;
	bit       steady = 1'b0;
	int       stall_style = 0;
	int       style_left = 0;
	int       hold_left = 0;

	function automatic void clear_history();
		for (int i = 0; i < WIN; i++)
			win_q[i] = 8'h00;
		rx_count = 0;
		tick_cnt = '0;
		cur_tag = '0;
	endfunction

	function automatic void model_write(logic [2:0] idx, logic [63:0] d);
		case (idx)
			REG_MATCH_MODE: m_mode = d[1:0];
			REG_TIMEOUT:    m_timeout = d[15:0];
			REG_TAG_LENGTH: m_len = d[4:0];
			REG_TAG_LOW:    m_low = d;
			REG_TAG_HIGH:   m_high = d;
			default: ;
		endcase
	endfunction

	function automatic int tag_len_of(int k);
		if (k == CUSTOM_SLOT)
			return int'(m_len);
		return RESP_LEN[k];
	endfunction

	// byte i counted from the start of the tag
	function automatic logic [7:0] tag_byte(int k, int i);
		if (k != CUSTOM_SLOT)
			return RESP_TAG[k][8*(RESP_LEN[k]-1-i) +: 8];
		if (i < 8)
			return m_low[8*i +: 8];
		return m_high[8*(i-8) +: 8];
	endfunction

	function automatic bit tail_is(int k);
		int len;
		len = tag_len_of(k);
		if (len < 1 || len > WIN || rx_count < len)
			return 1'b0;
		for (int i = 0; i < len; i++)
			if (win_q[WIN-len+i] != tag_byte(k, i))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic verdict_t detect_step(atd_action_t a, logic [7:0] b);
		verdict_t v;
		bit hit;
		hit = 1'b0;
		case (a)
			ACT_BYTE: begin
				for (int i = 0; i < WIN-1; i++)
					win_q[i] = win_q[i+1];
				win_q[WIN-1] = b;
				if (rx_count < COUNT_CAP)
					rx_count++;
				if (cur_st == ST_WAIT) begin
					if (m_mode == MODE_TABLE) begin
						// first hit in table order wins
						for (int k = 0; k < TABLE_COUNT; k++)
							if (!hit && tail_is(k)) begin
								hit = 1'b1;
								cur_tag = k[2:0];
							end
					end else if (m_mode == MODE_SUFFIX || m_mode == MODE_ANYWHERE) begin
						// anywhere mode needs the tag to start after the first byte
						hit = tail_is(CUSTOM_SLOT) &&
							!(m_mode == MODE_ANYWHERE && rx_count < int'(m_len) + 1);
						if (hit)
							cur_tag = TAG_IDX_CUSTOM;
					end
					if (hit)
						cur_st = ST_MATCH;
				end
			end
			ACT_TICK: begin
				if (cur_st == ST_WAIT) begin
					if (tick_cnt != 16'hFFFF)
						tick_cnt++;
					if (tick_cnt >= m_timeout)
						cur_st = ST_TIMEOUT;
				end
			end
			ACT_RESTART: begin
				clear_history();
				cur_st = (m_timeout == 16'd0) ? ST_TIMEOUT : ST_WAIT;
			end
			default: ;
		endcase
		v.st = cur_st;
		v.tag = (cur_st == ST_MATCH) ? cur_tag : 3'd0;
		v.ok = (cur_st == ST_MATCH) && !(m_mode == MODE_TABLE && cur_tag == TAG_IDX_FAIL);
		return v;
	endfunction

	function automatic plan_row_t beat_row(atd_action_t a, logic [7:0] b);
		plan_row_t r;
		r.wr = 1'b0;
		r.idx = '0;
		r.data = '0;
		r.act = a;
		r.rx = b;
		r.known = 1'b0;
		r.want.st = ST_WAIT;
		r.want.tag = '0;
		r.want.ok = 1'b0;
		return r;
	endfunction

	function automatic plan_row_t checked_row(atd_action_t a, logic [7:0] b, atd_status_t st,
			logic [2:0] tag, logic ok);
		plan_row_t r;
		r = beat_row(a, b);
		r.known = 1'b1;
		r.want.st = st;
		r.want.tag = tag;
		r.want.ok = ok;
		return r;
	endfunction

	function automatic plan_row_t reg_row(logic [2:0] idx, logic [63:0] d);
		plan_row_t r;
		r = beat_row(ACT_NONE, 8'h00);
		r.wr = 1'b1;
		r.idx = idx;
		r.data = d;
		return r;
	endfunction

	task automatic flag_field(string what, logic [7:0] want, logic [7:0] got);
		errors++;
		$display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
	endtask

	task automatic pace();
		int gap;
		if (steady || burst_left > 0) begin
			if (burst_left > 0)
				burst_left--;
		end else begin
			in_valid <= 1'b0;
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 24);
		end
	endtask

	task automatic send_beat(atd_action_t a, logic [7:0] b, bit known, verdict_t want);
		verdict_t calc;
		in_valid <= 1'b1;
		cfg_write <= 1'b0;
		action <= a;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		calc = detect_step(a, b);
		verdict_q.push_back(known ? want : calc);
		if (a != ACT_NONE)
			beats_sent++;
		pace();
	endtask

	// block must be idle before a register write
	task automatic drain();
		in_valid <= 1'b0;
		cfg_write <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] d);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		model_write(idx, d);
	endtask

	// result side: compare and stall pattern
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result beat: status %0d tag %0d ok %0d",
					$time, status, tag_index, command_ok);
			end else begin
				head = verdict_q.pop_front();
				if (status !== head.st)
					flag_field("status", {6'b0, head.st}, {6'b0, status});
				if (tag_index !== head.tag)
					flag_field("tag_index", {5'b0, head.tag}, {5'b0, tag_index});
				if (command_ok !== head.ok)
					flag_field("command_ok", {7'b0, head.ok}, {7'b0, command_ok});
			end
		end
		if (style_left == 0) begin
			stall_style = $urandom_range(0, 3);
			style_left = $urandom_range(32, 400);
		end else begin
			style_left--;
		end
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 9) < 7);
			default: begin
				if (hold_left > 0)
					hold_left--;
				else if ($urandom_range(0, 7) == 0)
					hold_left = $urandom_range(1, 20);
				out_stall <= (hold_left > 0);
			end
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		plan_row_t plan [$];
		verdict_t  blank;
		int        r, k, len, cut, flip, start, phase_end;

		m_mode = MODE_TABLE;
		m_timeout = 16'd1000;
		m_len = 5'd2;
		m_low = 64'h203E;
		m_high = 64'h0;
		clear_history();
		cur_st = ST_WAIT;
		blank.st = ST_WAIT;
		blank.tag = '0;
		blank.ok = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		plan.push_back(reg_row(REG_SPARE, '1));
		plan.push_back(checked_row(ACT_NONE, 8'hA5, ST_WAIT, 3'd0, 1'b0));
		plan.push_back(beat_row(ACT_BYTE, 8'hFF));
		plan.push_back(beat_row(ACT_BYTE, 8'h00));
		plan.push_back(beat_row(ACT_TICK, 8'hFF));
		plan.push_back(checked_row(ACT_RESTART, 8'h00, ST_WAIT, 3'd0, 1'b0));
		for (int i = 0; i < RESP_LEN[TAG_IDX_FAIL] - 1; i++)
			plan.push_back(beat_row(ACT_BYTE, tag_byte(int'(TAG_IDX_FAIL), i)));
		plan.push_back(checked_row(ACT_BYTE,
			tag_byte(int'(TAG_IDX_FAIL), RESP_LEN[TAG_IDX_FAIL] - 1),
			ST_MATCH, TAG_IDX_FAIL, 1'b0));
		plan.push_back(checked_row(ACT_TICK, 8'h00, ST_MATCH, TAG_IDX_FAIL, 1'b0));
		plan.push_back(reg_row(REG_TIMEOUT, 64'd0));
		plan.push_back(checked_row(ACT_RESTART, 8'h00, ST_TIMEOUT, 3'd0, 1'b0));
		plan.push_back(reg_row(REG_TIMEOUT, 64'd1));
		plan.push_back(checked_row(ACT_RESTART, 8'h00, ST_WAIT, 3'd0, 1'b0));
		plan.push_back(checked_row(ACT_TICK, 8'h00, ST_TIMEOUT, 3'd0, 1'b0));
		plan.push_back(reg_row(REG_MATCH_MODE, 64'(MODE_ANYWHERE)));
		plan.push_back(checked_row(ACT_RESTART, 8'h00, ST_WAIT, 3'd0, 1'b0));
		plan.push_back(beat_row(ACT_BYTE, 8'h3E));
		// tag fits but starts at the first byte
		plan.push_back(checked_row(ACT_BYTE, 8'h20, ST_WAIT, 3'd0, 1'b0));
		plan.push_back(beat_row(ACT_BYTE, 8'h3E));
		plan.push_back(checked_row(ACT_BYTE, 8'h20, ST_MATCH, TAG_IDX_CUSTOM, 1'b1));

		foreach (plan[i]) begin
			if (plan[i].wr) begin
				drain();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_beat(plan[i].act, plan[i].rx, plan[i].known, plan[i].want);
			end
		end

		// random phases, each with a fresh register set
		start = beats_sent;
		while (beats_sent - start < RANDOM_ITEMS) begin
			drain();
			r = $urandom_range(0, 9);
			write_reg(REG_MATCH_MODE, 64'((r < 4) ? MODE_TABLE : (r < 6) ? MODE_SUFFIX :
				(r < 9) ? MODE_ANYWHERE : MODE_OFF));
			r = $urandom_range(0, 9);
			write_reg(REG_TIMEOUT, (r == 0) ? 64'd0 : (r == 1) ? 64'd1 :
				(r == 2) ? 64'hFFFF : (r == 3) ? 64'($urandom_range(0, 65535)) :
				64'($urandom_range(2, 60)));
			r = $urandom_range(0, 9);
			write_reg(REG_TAG_LENGTH, (r == 0) ? 64'd0 : (r == 1) ? 64'd16 :
				(r == 2) ? 64'($urandom_range(17, 31)) : (r == 3) ? 64'd1 :
				64'($urandom_range(2, 15)));
			r = $urandom_range(0, 5);
			write_reg(REG_TAG_LOW, (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom});
			r = $urandom_range(0, 5);
			write_reg(REG_TAG_HIGH, (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom});
			steady = ($urandom_range(0, 3) == 0);
			phase_end = beats_sent + $urandom_range(20, 80);

			while (beats_sent < phase_end) begin
				if ($urandom_range(0, 9) < 7) begin
					// usually a restart, some noise, then a response ending
					if ($urandom_range(0, 4) != 0)
						send_beat(ACT_RESTART, 8'($urandom), 1'b0, blank);
					repeat ($urandom_range(0, 4))
						send_beat(($urandom_range(0, 3) == 0) ? ACT_TICK : ACT_BYTE,
							8'($urandom), 1'b0, blank);
					k = (m_mode == MODE_TABLE || $urandom_range(0, 5) == 0) ?
						$urandom_range(0, TABLE_COUNT - 1) : CUSTOM_SLOT;
					len = tag_len_of(k);
					if (len < 1 || len > WIN)
						len = $urandom_range(1, 4);
					cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : len;
					flip = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
					for (int i = 0; i < cut; i++)
						send_beat(ACT_BYTE, tag_byte(k, i) ^
							((i == flip) ? 8'(1 << $urandom_range(0, 7)) : 8'h00),
							1'b0, blank);
					repeat ($urandom_range(0, 3))
						send_beat(($urandom_range(0, 2) == 0) ? ACT_TICK : ACT_BYTE,
							8'($urandom), 1'b0, blank);
				end else begin
					repeat ($urandom_range(1, 8))
						send_beat(atd_action_t'($urandom_range(0, 3)), 8'($urandom),
							1'b0, blank);
				end
			end
		end

		drain();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
